[sv/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Result codes and the command beat that the parser hands to the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CP_W = 21;

	localparam logic [2:0] KIND_DATA    = 3'd0;
	localparam logic [2:0] KIND_END     = 3'd1;
	localparam logic [2:0] KIND_NOQUOTE = 3'd2;
	localparam logic [2:0] KIND_BADESC  = 3'd3;
	localparam logic [2:0] KIND_BADCHAR = 3'd4;
	localparam logic [2:0] KIND_BADHEX  = 3'd5;
	localparam logic [2:0] KIND_BADSUR  = 3'd6;

	// One queued command: a code point to encode (kind data) or a status
	// beat (code point zero). raw: cp[7:0] goes out as one byte, unencoded.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [2:0]      kind;
		logic            raw;
	} cmd_t;

endpackage

`default_nettype wire

[sv/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front: byte parser
// Tracks string/escape/hex state and emits one command per byte with output.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              take,
	input  wire [7:0]        in_byte,
	output logic             push,
	output jsu_pkg::cmd_t    cmd
);
	import jsu_pkg::*;

	typedef enum logic [6:0] {
		M_IDLE   = 7'b0000001,
		M_STR    = 7'b0000010,
		M_ESC    = 7'b0000100,
		M_HEX1   = 7'b0001000,
		M_SUR_BS = 7'b0010000,
		M_SUR_U  = 7'b0100000,
		M_HEX2   = 7'b1000000
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] code_q, code_d;
	logic [9:0]  hi_q, hi_d;

	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] code_nx;
	logic [19:0] pair;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= "0" && in_byte <= "9") begin
			hex_val = 4'(in_byte - "0");
		end else if (in_byte >= "A" && in_byte <= "F") begin
			hex_val = 4'(in_byte - "A" + 8'd10);
		end else if (in_byte >= "a" && in_byte <= "f") begin
			hex_val = 4'(in_byte - "a" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign code_nx = {code_q[11:0], hex_val};
	assign pair    = {hi_q, code_nx[9:0]};

	always_comb begin
		mode_d   = mode_q;
		hcnt_d   = hcnt_q;
		code_d   = code_q;
		hi_d     = hi_q;
		push     = 1'b0;
		cmd.cp   = '0;
		cmd.kind = KIND_DATA;
		cmd.raw  = 1'b0;
		unique case (mode_q)
			M_IDLE: begin
				if (in_byte == "\"") mode_d = M_STR;
			end
			M_STR: begin
				if (in_byte == "\"") begin
					mode_d   = M_IDLE;
					push     = 1'b1;
					cmd.kind = KIND_END;
				end else if (in_byte == 8'h00) begin
					mode_d   = M_IDLE;
					push     = 1'b1;
					cmd.kind = KIND_NOQUOTE;
				end else if (in_byte == "\\") begin
					mode_d = M_ESC;
				end else if (in_byte < 8'h20) begin
					mode_d   = M_IDLE;
					push     = 1'b1;
					cmd.kind = KIND_BADCHAR;
				end else begin
					// plain text byte passes through as is
					push    = 1'b1;
					cmd.cp  = CP_W'(in_byte);
					cmd.raw = 1'b1;
				end
			end
			M_ESC: begin
				push   = 1'b1;
				mode_d = M_STR;
				case (in_byte)
					"\"", "\\", "/": cmd.cp = CP_W'(in_byte);
					"b": cmd.cp = CP_W'(8'h08);
					"f": cmd.cp = CP_W'(8'h0C);
					"n": cmd.cp = CP_W'(8'h0A);
					"r": cmd.cp = CP_W'(8'h0D);
					"t": cmd.cp = CP_W'(8'h09);
					"u": begin
						push   = 1'b0;
						mode_d = M_HEX1;
						hcnt_d = 2'd0;
						code_d = '0;
					end
					default: begin
						mode_d   = M_IDLE;
						cmd.kind = KIND_BADESC;
					end
				endcase
			end
			M_HEX1, M_HEX2: begin
				if (!hex_ok) begin
					mode_d   = M_IDLE;
					push     = 1'b1;
					cmd.kind = KIND_BADHEX;
				end else begin
					code_d = code_nx;
					hcnt_d = hcnt_q + 2'd1;
					if (hcnt_q == 2'd3) begin
						if (mode_q == M_HEX1) begin
							// high surrogate: hold its payload bits
							if (code_nx[15:10] == 6'b110110) begin
								hi_d   = code_nx[9:0];
								mode_d = M_SUR_BS;
							end else begin
								mode_d = M_STR;
								push   = 1'b1;
								cmd.cp = CP_W'(code_nx);
							end
						end else if (code_nx[15:10] == 6'b110111) begin
							mode_d = M_STR;
							push   = 1'b1;
							cmd.cp = CP_W'(pair) + CP_W'(21'h10000);
						end else begin
							mode_d   = M_IDLE;
							push     = 1'b1;
							cmd.kind = KIND_BADSUR;
						end
					end
				end
			end
			M_SUR_BS: begin
				if (in_byte == "\\") begin
					mode_d = M_SUR_U;
				end else begin
					mode_d   = M_IDLE;
					push     = 1'b1;
					cmd.kind = KIND_BADSUR;
				end
			end
			M_SUR_U: begin
				if (in_byte == "u") begin
					mode_d = M_HEX2;
					hcnt_d = 2'd0;
					code_d = '0;
				end else begin
					mode_d   = M_IDLE;
					push     = 1'b1;
					cmd.kind = KIND_BADSUR;
				end
			end
			default: begin
				mode_d = M_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hcnt_q <= '0;
			code_q <= '0;
			hi_q   <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			hcnt_q <= hcnt_d;
			code_q <= code_d;
			hi_q   <= hi_d;
		end
	end

endmodule

`default_nettype wire

[sv/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue: command queue
// Small FIFO between parser and encoder so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire jsu_pkg::cmd_t    push_cmd,
	output logic                  full,
	input  wire                   pop,
	output jsu_pkg::cmd_t         head,
	output logic                  empty
);
	import jsu_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

[sv/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back: UTF-8 encoder
// Walks the head command one output byte per cycle into the output register while no result waits on result_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire jsu_pkg::cmd_t    head,
	input  wire                   empty,
	output logic                  pop,
	output logic                  result_valid,
	input  wire                   result_ready,
	output logic [7:0]            data_byte,
	output logic [2:0]            kind,
	output logic                  last_of_run
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] nlast;
	logic [7:0] byte_sel;
	logic       load, is_last;
	logic       vld_q;
	logic [7:0] data_q;
	logic [2:0] kind_q;
	logic       last_q;

	// index of the final byte of the head command; raw and status beats are one byte
	always_comb begin
		if (head.kind != KIND_DATA || head.raw || head.cp <= CP_W'(21'h7F)) nlast = 2'd0;
		else if (head.cp <= CP_W'(21'h7FF))                   nlast = 2'd1;
		else if (head.cp <= CP_W'(21'hFFFF))                  nlast = 2'd2;
		else                                                  nlast = 2'd3;
	end

	always_comb begin
		byte_sel = 8'h80 | {2'b00, head.cp[5:0]};
		case (nlast)
			2'd0: byte_sel = head.cp[7:0];
			2'd1: if (idx_q == 2'd0) byte_sel = 8'hC0 | {3'b000, head.cp[10:6]};
			2'd2: begin
				if (idx_q == 2'd0)      byte_sel = 8'hE0 | {4'b0000, head.cp[15:12]};
				else if (idx_q == 2'd1) byte_sel = 8'h80 | {2'b00, head.cp[11:6]};
			end
			default: begin
				if (idx_q == 2'd0)      byte_sel = 8'hF0 | {5'b00000, head.cp[20:18]};
				else if (idx_q == 2'd1) byte_sel = 8'h80 | {2'b00, head.cp[17:12]};
				else if (idx_q == 2'd2) byte_sel = 8'h80 | {2'b00, head.cp[11:6]};
			end
		endcase
	end

	assign load    = !vld_q || result_ready;
	assign is_last = (idx_q == nlast);
	assign pop     = load && !empty && is_last;

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			data_q <= byte_sel;
			kind_q <= head.kind;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= !empty;
			if (!empty) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	assign result_valid = vld_q;
	assign data_byte    = data_q;
	assign kind         = kind_q;
	assign last_of_run  = last_q;

endmodule

`default_nettype wire

[sv/json_string_unescape_utf8_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit: JSON string unescaper with UTF-8 output
// Parses a quoted JSON string byte by byte, resolves escapes and surrogate
// pairs, and streams the decoded text as UTF-8 bytes plus status beats.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------
//  input    | byte_valid / byte_ready     | in_byte[7:0]
//  result   | result_valid / result_ready | data_byte[7:0], kind[2:0],
//           |                             | last_of_run
//
// The parser takes one input beat per cycle; it stalls only when the
// four-entry command queue is full. The encoder drains a queued command
// one UTF-8 byte at a time while the parser keeps taking beats until the
// queue fills; each command goes from the queue head into the output
// register. Reset puts the parser in idle (awaiting an opening quote) and
// empties the queue and the output register. A stalled result side backs
// up into the queue first, then into byte_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	output logic       byte_ready,
	input  wire [7:0]  in_byte,
	output logic       result_valid,
	input  wire        result_ready,
	output logic [7:0] data_byte,
	output logic [2:0] kind,
	output logic       last_of_run
);
	import jsu_pkg::*;

	logic take;
	logic push;
	cmd_t push_cmd;
	cmd_t head;
	logic full, empty, pop;

	assign byte_ready = !full;
	assign take       = byte_valid && byte_ready;

	// front: parser state machine, one command per productive byte
	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (in_byte),
		.push    (push),
		.cmd     (push_cmd)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && take),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// back: UTF-8 byte sequencer and output register
	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.data_byte    (data_byte),
		.kind         (kind),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire
